// ===== sv/wma_pkg.sv =====
// ---------------------------------------------------------------------------
// wma_pkg
// shared sizes and types of the windowed moving average block
// ---------------------------------------------------------------------------
package wma_pkg;

  localparam int DEPTH    = 60;
  localparam int SAMPLE_W = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W    = SAMPLE_W + CNT_W;
  localparam int STEP_W   = $clog2(SUM_W + 1);

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic             sub;
  } wma_add_req_t;

endpackage

// ===== sv/wma_ram.sv =====
// ---------------------------------------------------------------------------
// wma_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
module wma_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 60,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== sv/wma_addsub.sv =====
// ---------------------------------------------------------------------------
// wma_addsub
// shared wide adder / subtractor for accumulate, negate and divide steps
// ---------------------------------------------------------------------------
module wma_addsub
  import wma_pkg::*;
(
  input  wma_add_req_t     req,
  output logic [SUM_W-1:0] sum,
  output logic             carry
);

  logic [SUM_W-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign {carry, sum} = {1'b0, req.a} + {1'b0, b_op} + {{SUM_W{1'b0}}, req.sub};

endmodule

// ===== sv/windowed_moving_average.sv =====
// ---------------------------------------------------------------------------
// windowed_moving_average
// truncated mean over the filled slots of a sample ring
// ---------------------------------------------------------------------------
// input channel: in_valid / in_stall with in_sample_value and in_measure_ok.
// a good sample is written to the ring at the accept edge; every transaction
// raises the fill level, saturating at DEPTH.
// result channel: out_valid / out_stall with out_average, one per input.
// one shared adder does all the work under a small sequencer:
//   sum    one ring read per filled slot, one per cycle (registered ram)
//   abs    negate a negative sum
//   divide SUM_W restoring steps (38 at DEPTH 60), one per cycle
//   result sign restored, into the output register
// one item at a time: in_stall is high from accept until the result is
// registered. the next transaction may be accepted while a result waits.
// if out_stall holds the previous result, the sequencer waits in its last
// step and the output register keeps its value.
// reset: ring reads as zero (per-slot valid bits), fill and write position
// zero, no result pending.
// ---------------------------------------------------------------------------
module windowed_moving_average
  import wma_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_measure_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_average
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_ABS  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_r;
  logic [CNT_W-1:0]    fill_r;
  logic [ADDR_W-1:0]   wr_pos_r;
  logic [DEPTH-1:0]    valid_r;
  logic                pend_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_average_r;
  logic [CNT_W-1:0]    idx_r;
  logic [SUM_W-1:0]    acc_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic                neg_r;
  logic [STEP_W-1:0]   step_r;
  logic                vld_q_r;

  logic                accept;
  logic                issue;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] data_m;
  logic [CNT_W:0]      trial;
  logic                out_free;
  wma_add_req_t        req;
  logic [SUM_W-1:0]    add_sum;
  logic                add_carry;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign issue    = (state_r == S_SUM) && (idx_r < fill_r);
  assign rd_en    = issue;
  assign rd_addr  = idx_r[ADDR_W-1:0];
  assign data_m   = rd_data & {SAMPLE_W{vld_q_r}};
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  wma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (accept && in_measure_ok),
    .wr_addr(wr_pos_r),
    .wr_data(in_sample_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  wma_addsub u_addsub (
    .req  (req),
    .sum  (add_sum),
    .carry(add_carry)
  );

  always_comb begin
    req = '{a: '0, b: '0, sub: 1'b0};
    unique case (state_r)
      S_SUM: begin
        req.a = acc_r;
        req.b = {{(SUM_W-SAMPLE_W){data_m[SAMPLE_W-1]}}, data_m};
      end
      S_ABS: begin
        req.b   = acc_r;
        req.sub = 1'b1;
      end
      S_DIV: begin
        req.a   = {{(SUM_W-CNT_W-1){1'b0}}, trial};
        req.b   = {{(SUM_W-CNT_W){1'b0}}, fill_r};
        req.sub = 1'b1;
      end
      S_DONE: begin
        req.b   = quo_r;
        req.sub = neg_r;
      end
      default: begin
        req.sub = 1'b0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      wr_pos_r    <= '0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SUM;
            if (fill_r < CNT_W'(DEPTH)) begin
              fill_r <= fill_r + 1'b1;
            end
            if (in_measure_ok) begin
              valid_r[wr_pos_r] <= 1'b1;
              wr_pos_r <= (wr_pos_r == ADDR_W'(DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
            end
          end
        end
        S_SUM: begin
          if (!issue && !pend_r) begin
            state_r <= S_ABS;
          end
        end
        S_ABS: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r == STEP_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_q_r <= valid_r[rd_addr];
    end
    unique case (state_r)
      S_IDLE: begin
        idx_r <= '0;
        acc_r <= '0;
      end
      S_SUM: begin
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (pend_r) begin
          acc_r <= add_sum;
        end
      end
      S_ABS: begin
        neg_r  <= acc_r[SUM_W-1];
        quo_r  <= acc_r[SUM_W-1] ? add_sum : acc_r;
        rem_r  <= '0;
        step_r <= STEP_W'(SUM_W);
      end
      S_DIV: begin
        rem_r  <= add_carry ? add_sum[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], add_carry};
        step_r <= step_r - 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_average_r <= add_sum[SAMPLE_W-1:0];
        end
      end
      default: begin
        idx_r <= '0;
      end
    endcase
  end

endmodule

// ===== sv/wma_checker.sv =====
// ---------------------------------------------------------------------------
// wma_checker
// port level checks of the windowed moving average block
// ---------------------------------------------------------------------------
module wma_checker
  import wma_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] in_sample_value,
  input logic                       in_measure_ok,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [SAMPLE_W-1:0] out_average
);

  // busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result is only produced by a busy block
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // no result pending out of reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled result changed");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> $stable(in_sample_value) && $stable(in_measure_ok))
    else $error("stalled input changed");

endmodule

bind windowed_moving_average wma_checker u_wma_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_sample_value(in_sample_value),
  .in_measure_ok  (in_measure_ok),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_average    (out_average)
);

// ===== test/windowed_moving_average_tb.sv =====
// ---------------------------------------------------------------------------
// windowed_moving_average_tb
// self-checking bench for the moving average over a sample ring
// ---------------------------------------------------------------------------
// a short table of measurement events comes first: full-scale samples, failed
// measurements that still grow the window and unwritten slots that read as
// zero. the random part follows in segments of different character: full
// range, small values around zero, extremes, flat runs of one value, and
// mostly failed measurements. every average is compared with a predictor
// that keeps its own copy of the ring, or with a fixed value for the first
// three table rows. the sender works in bursts and the receiver stalls in
// changing patterns. once the output is held off long enough to back up the
// input, and once the sender waits for the block to drain.
// ---------------------------------------------------------------------------
module windowed_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wma_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 8;
  localparam int NUM_ITEMS      = 1850;
  localparam int LATENCY_MAX    = DEPTH + SUM_W + 4;
  localparam int HOLD_CYCLES    = 3 * LATENCY_MAX;
  localparam int DRAIN_CYCLES   = 2 * LATENCY_MAX;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY_MAX;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_AT_ITEM   = 500;
  localparam int PAUSE_AT_ITEM  = 1200;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fffffff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh80000000;
  localparam logic signed [SAMPLE_W-1:0] ALL_ONES   = 32'shffffffff;

  typedef enum int {
    SEG_FULL,
    SEG_SMALL,
    SEG_EXTREME,
    SEG_FLAT,
    SEG_FAILING
  } segment_kind_e;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ok;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] average;
  } event_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam event_row_t DIRECTED_EVENTS [NUM_DIRECTED] = '{
    '{SAMPLE_MAX,     1'b1, 1'b1, SAMPLE_MAX},
    '{SAMPLE_MIN,     1'b1, 1'b1, 32'sd0},
    '{32'sd0,         1'b0, 1'b1, 32'sd0},
    '{SAMPLE_MIN,     1'b1, 1'b0, 32'sd0},
    '{ALL_ONES,       1'b1, 1'b0, 32'sd0},
    '{32'sh55555555,  1'b0, 1'b0, 32'sd0},
    '{32'shaaaaaaaa,  1'b1, 1'b0, 32'sd0},
    '{32'sh55555555,  1'b1, 1'b0, 32'sd0},
    '{32'sd1,         1'b1, 1'b0, 32'sd0},
    '{ALL_ONES,       1'b0, 1'b0, 32'sd0},
    '{-32'sd7,        1'b1, 1'b0, 32'sd0},
    '{32'sd0,         1'b1, 1'b0, 32'sd0},
    '{SAMPLE_MAX,     1'b0, 1'b0, 32'sd0},
    '{SAMPLE_MIN,     1'b0, 1'b0, 32'sd0},
    '{32'sd3,         1'b1, 1'b0, 32'sd0},
    '{-32'sd3,        1'b1, 1'b0, 32'sd0},
    '{SAMPLE_MAX,     1'b1, 1'b0, 32'sd0},
    '{SAMPLE_MAX,     1'b1, 1'b0, 32'sd0},
    '{SAMPLE_MIN,     1'b1, 1'b0, 32'sd0},
    '{32'sh0000ffff,  1'b1, 1'b0, 32'sd0},
    '{32'shffff0000,  1'b0, 1'b0, 32'sd0},
    '{-32'sd1000,     1'b1, 1'b0, 32'sd0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                       in_measure_ok = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;

  logic signed [SAMPLE_W-1:0] ring_copy [DEPTH];
  int                         write_slot = 0;
  int                         fill_count = 0;

  logic signed [SAMPLE_W-1:0] expected_averages [$];

  int  error_count    = 0;
  int  events_sent    = 0;
  int  failed_events  = 0;
  int  averages_seen  = 0;
  int  burst_left     = 0;
  int  holds_done     = 0;
  bit  hold_request   = 1'b0;

  windowed_moving_average u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_measure_ok   (in_measure_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [SAMPLE_W-1:0] predict_average(
    input logic signed [SAMPLE_W-1:0] sample,
    input logic                       ok
  );
    longint total;
    if (fill_count < DEPTH) fill_count++;
    if (ok) begin
      ring_copy[write_slot] = sample;
      write_slot = (write_slot == DEPTH - 1) ? 0 : write_slot + 1;
    end
    total = 0;
    for (int i = 0; i < fill_count; i++) total += longint'(ring_copy[i]);
    return SAMPLE_W'(total / longint'(fill_count));
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // burst pacing: at the start of each burst the sender may go quiet for a while
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_event(
    input logic signed [SAMPLE_W-1:0] sample,
    input logic                       ok,
    input logic                       typed,
    input logic signed [SAMPLE_W-1:0] typed_average
  );
    logic signed [SAMPLE_W-1:0] predicted;
    in_sample_value <= sample;
    in_measure_ok   <= ok;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_average(sample, ok);
    expected_averages.push_back(typed ? typed_average : predicted);
    events_sent++;
    if (!ok) failed_events++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_averages
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        report_error($sformatf("average %0d with no transaction waiting", out_average));
      end else begin
        want = expected_averages.pop_front();
        averages_seen++;
        if (out_average !== want)
          report_error($sformatf("average mismatch on result %0d: expected %0d, got %0d",
                                 averages_seen, want, out_average));
      end
    end
  end

  initial begin : receiver_pattern
    stall_mode_e mode;
    int          left;
    int          period;
    int          tick;
    mode   = STALL_NONE;
    left   = 0;
    period = 2;
    tick   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        holds_done++;
      end
      if (left == 0) begin
        mode   = stall_mode_e'($urandom_range(0, 3));
        left   = $urandom_range(20, 200);
        period = $urandom_range(2, 6);
      end
      left--;
      tick++;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
        default:     out_stall <= (tick % period == 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("[%0t] ERROR: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    segment_kind_e              seg_kind;
    int                         seg_left;
    logic signed [SAMPLE_W-1:0] flat_value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ok;
    seg_kind   = SEG_FULL;
    seg_left   = 0;
    flat_value = '0;
    foreach (ring_copy[i]) ring_copy[i] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_EVENTS[i]) begin
      pace_sender();
      send_event(DIRECTED_EVENTS[i].sample, DIRECTED_EVENTS[i].ok,
                 DIRECTED_EVENTS[i].typed, DIRECTED_EVENTS[i].average);
    end

    for (int n = NUM_DIRECTED; n < NUM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) hold_request = 1'b1;
      if (n == PAUSE_AT_ITEM) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_averages.size() != 0);
      end
      if (seg_left == 0) begin
        seg_kind = segment_kind_e'($urandom_range(0, 4));
        seg_left = $urandom_range(10, 90);
        case ($urandom_range(0, 3))
          0:       flat_value = SAMPLE_MAX;
          1:       flat_value = SAMPLE_MIN;
          2:       flat_value = ALL_ONES;
          default: flat_value = $urandom;
        endcase
      end
      seg_left--;
      case (seg_kind)
        SEG_FULL: begin
          sample = $urandom;
          ok     = ($urandom_range(0, 99) < 85);
        end
        SEG_SMALL: begin
          sample = $urandom_range(0, 200);
          sample = sample - 32'sd100;
          ok     = ($urandom_range(0, 99) < 80);
        end
        SEG_EXTREME: begin
          case ($urandom_range(0, 3))
            0:       sample = SAMPLE_MAX;
            1:       sample = SAMPLE_MIN;
            2:       sample = SAMPLE_MAX - $urandom_range(0, 3);
            default: sample = SAMPLE_MIN + $urandom_range(0, 3);
          endcase
          ok = ($urandom_range(0, 99) < 90);
        end
        SEG_FLAT: begin
          sample = flat_value;
          ok     = 1'b1;
        end
        default: begin
          sample = $urandom;
          ok     = ($urandom_range(0, 99) < 20);
        end
      endcase
      pace_sender();
      send_event(sample, ok, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_averages.size() != 0)
      report_error($sformatf("%0d averages never arrived", expected_averages.size()));

    $display("run covered %0d measurement events (%0d failed) and %0d checked averages",
             events_sent, failed_events, averages_seen);
    $display("window filled to %0d slots, %0d long output hold-off(s), %0d error(s)",
             fill_count, holds_done, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
